/* hdl/lbc_pkg.sv */
// Shared types, constants and helper functions for the layer blend compositor.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package lbc_pkg;

  // Geometry of one input word.
  localparam int INPUT_LAYERS   = 3;
  localparam int CHANNELS       = 3;
  localparam int MAX_LAYERS_DEF = 3;

  // Register stages in one lane of one layer.
  localparam int LANE_STAGES = 4;

  // Channel positions inside a pixel.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // Arithmetic constants.
  localparam logic [7:0]  PIX_MAX     = 8'd255;
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [14:0] MIX_MAX     = 15'd25500;
  // floor(y / 100) equals (y * 5243) >> 19 for every y up to 25500.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef logic [7:0] px_t;
  typedef logic [CHANNELS-1:0][7:0] pix_t;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_LITE = 3'd3,
    MODE_DIFF = 3'd4
  } blend_mode_t;

  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_MODE_L1     = 3'd1,
    REG_MODE_L2     = 3'd2,
    REG_MODE_L3     = 3'd3,
    REG_KEEP_L1     = 3'd4,
    REG_KEEP_L2     = 3'd5,
    REG_KEEP_L3     = 3'd6
  } reg_idx_t;

  // Settings as seen by the datapath; keep is already clamped to 100.
  typedef struct packed {
    logic [1:0]                    layer_count;
    logic [INPUT_LAYERS-1:0][2:0]  mode;
    logic [INPUT_LAYERS-1:0][6:0]  keep;
  } cfg_t;

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic px_t div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

/* hdl/lbc_cfg_regs.sv */
// Configuration register file of the layer blend compositor.
// Depends on lbc_pkg for the register index codes and the settings struct.
`default_nettype none

module lbc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [6:0]    cfg_wdata,
  output lbc_pkg::cfg_t      cfg_o
);

  logic [1:0] layer_count_r;
  logic [lbc_pkg::INPUT_LAYERS-1:0][2:0] mode_r;
  logic [lbc_pkg::INPUT_LAYERS-1:0][6:0] keep_r;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= 2'd3;
      mode_r        <= '0;
      keep_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lbc_pkg::REG_LAYER_COUNT: layer_count_r <= cfg_wdata[1:0];
        lbc_pkg::REG_MODE_L1:     mode_r[0] <= cfg_wdata[2:0];
        lbc_pkg::REG_MODE_L2:     mode_r[1] <= cfg_wdata[2:0];
        lbc_pkg::REG_MODE_L3:     mode_r[2] <= cfg_wdata[2:0];
        lbc_pkg::REG_KEEP_L1:     keep_r[0] <= cfg_wdata;
        lbc_pkg::REG_KEEP_L2:     keep_r[1] <= cfg_wdata;
        lbc_pkg::REG_KEEP_L3:     keep_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Keep values above 100 percent act as 100 percent.
  always_comb begin
    cfg_o.layer_count = layer_count_r;
    cfg_o.mode        = mode_r;
    for (int i = 0; i < lbc_pkg::INPUT_LAYERS; i++) begin
      cfg_o.keep[i] = (keep_r[i] > lbc_pkg::PCT_FULL) ? lbc_pkg::PCT_FULL : keep_r[i];
    end
  end

endmodule

`default_nettype wire

/* hdl/lbc_lane.sv */
// One channel lane of one layer: blend with the canvas, then percent mix.
// Depends on lbc_pkg for constants, the blend mode codes and div255.
`default_nettype none

module lbc_lane (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [lbc_pkg::LANE_STAGES-1:0]   stg_vld_i,
  input  wire lbc_pkg::px_t                      canvas_i,
  input  wire lbc_pkg::px_t                      px_i,
  input  wire logic [2:0]                        mode_i,
  input  wire logic [6:0]                        keep_i,
  input  wire logic                              active_i,
  output lbc_pkg::px_t                           canvas_o
);

  logic [15:0]   prod_r;
  lbc_pkg::px_t  cvs0_r;
  lbc_pkg::px_t  px0_r;
  lbc_pkg::px_t  blend_nxt;
  lbc_pkg::px_t  blend_r;
  lbc_pkg::px_t  cvs1_r;
  lbc_pkg::px_t  quot;
  logic [8:0]    add_sum;
  logic [14:0]   mix_nxt;
  logic [14:0]   mix_r;
  logic [27:0]   scl_r;

  // Stage 0: product for multiply mode, operands carried along.
  always_ff @(posedge clk) begin
    prod_r <= 16'(canvas_i) * 16'(px_i);
    cvs0_r <= canvas_i;
    px0_r  <= px_i;
  end

  // Stage 1: blend selection. An unused layer or an undefined mode passes the canvas.
  always_comb begin
    add_sum = {1'b0, cvs0_r} + {1'b0, px0_r};
    quot    = lbc_pkg::div255(prod_r);
    if (!active_i) begin
      blend_nxt = cvs0_r;
    end else begin
      case (mode_i)
        lbc_pkg::MODE_ADD:  blend_nxt = add_sum[8] ? lbc_pkg::PIX_MAX : add_sum[7:0];
        lbc_pkg::MODE_SUB:  blend_nxt = (cvs0_r > px0_r) ? (cvs0_r - px0_r) : '0;
        lbc_pkg::MODE_MUL:  blend_nxt = quot;
        lbc_pkg::MODE_LITE: blend_nxt = (cvs0_r > px0_r) ? cvs0_r : px0_r;
        lbc_pkg::MODE_DIFF: blend_nxt = (cvs0_r > px0_r) ? (cvs0_r - px0_r)
                                                         : (px0_r - cvs0_r);
        default:            blend_nxt = cvs0_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    blend_r <= blend_nxt;
    cvs1_r  <= cvs0_r;
  end

  // Stage 2: weighted sum of blended value and previous canvas.
  assign mix_nxt = 15'(blend_r) * 15'(lbc_pkg::PCT_FULL - keep_i)
                 + 15'(keep_i) * 15'(cvs1_r);

  always_ff @(posedge clk) begin
    mix_r <= mix_nxt;
  end

  // Stage 3: divide by 100 through a reciprocal multiply.
  always_ff @(posedge clk) begin
    scl_r <= 28'(mix_r) * 28'(lbc_pkg::RECIP_100);
  end

  assign canvas_o = scl_r[lbc_pkg::RECIP_SHIFT+7:lbc_pkg::RECIP_SHIFT];

  // The divide by 255 gives the floor of the product.
  a_div255: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_i[0] |-> (17'(quot) * 17'(lbc_pkg::PIX_MAX) <= 17'(prod_r)) &&
                     (17'(prod_r) < 17'(quot) * 17'(lbc_pkg::PIX_MAX) + 17'(lbc_pkg::PIX_MAX)))
    else $error("lbc_lane: multiply blend quotient is off");

  // The weighted sum stays in the range where the reciprocal is exact.
  a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_i[2] |-> mix_r <= lbc_pkg::MIX_MAX)
    else $error("lbc_lane: weighted sum out of range");

  // The lane result is the floor of the weighted sum over 100.
  a_mix_div: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_i[3] |-> (15'(canvas_o) * 15'(lbc_pkg::PCT_FULL) <= $past(mix_r)) &&
                     ($past(mix_r) < 15'(canvas_o) * 15'(lbc_pkg::PCT_FULL) +
                                     15'(lbc_pkg::PCT_FULL)))
    else $error("lbc_lane: percent mix quotient is off");

endmodule

`default_nettype wire

/* hdl/lbc_layer.sv */
// One layer step: three channel lanes side by side plus the word valid chain.
// Depends on lbc_pkg and lbc_lane.
`default_nettype none

module lbc_layer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  valid_i,
  input  wire lbc_pkg::pix_t         canvas_i,
  input  wire lbc_pkg::pix_t         px_i,
  input  wire logic [2:0]            mode_i,
  input  wire logic [6:0]            keep_i,
  input  wire logic                  active_i,
  output logic                       valid_o,
  output lbc_pkg::pix_t              canvas_o
);

  logic [lbc_pkg::LANE_STAGES-1:0] vld_r;

  // Valid flag of the word held in each lane stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[lbc_pkg::LANE_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_r[lbc_pkg::LANE_STAGES-1];

  // One lane per channel.
  for (genvar c = 0; c < lbc_pkg::CHANNELS; c++) begin : g_lane
    lbc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .stg_vld_i (vld_r),
      .canvas_i  (canvas_i[c]),
      .px_i      (px_i[c]),
      .mode_i    (mode_i),
      .keep_i    (keep_i),
      .active_i  (active_i),
      .canvas_o  (canvas_o[c])
    );
  end

  // A word only leaves the layer after it entered and passed every lane stage.
  a_layer_lat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> $past(valid_i, lbc_pkg::LANE_STAGES))
    else $error("lbc_layer: word left without entering");

endmodule

`default_nettype wire

/* hdl/layer_blend_compositor_unit.sv */
// Top level of the layer blend compositor: settings, layer chain and output register.
// Depends on lbc_pkg, lbc_cfg_regs, lbc_layer (and through it lbc_lane).
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+-------------------------------------------
//   input    | start, busy      | in_l1_* .. in_l3_* (blue, green, red, 8b)
//   result   | out_valid        | out_blue, out_green, out_red (8b)
//   settings | cfg_we           | cfg_index (3b), cfg_wdata (7b)
//
// One word is taken every clock; busy stays low.
// A word passes min(MAX_LAYERS, 3) layers of four lane stages each (product, blend,
// weighted sum, reciprocal divide) and then the output register.
// Reset restores the register defaults and clears all valid flags; the datapath
// registers are not reset.
// The receiver cannot stall: each result shows for one cycle with out_valid.
`default_nettype none

module layer_blend_compositor_unit #(
  parameter int MAX_LAYERS = lbc_pkg::MAX_LAYERS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_l1_blue,
  input  wire logic [7:0] in_l1_green,
  input  wire logic [7:0] in_l1_red,
  input  wire logic [7:0] in_l2_blue,
  input  wire logic [7:0] in_l2_green,
  input  wire logic [7:0] in_l2_red,
  input  wire logic [7:0] in_l3_blue,
  input  wire logic [7:0] in_l3_green,
  input  wire logic [7:0] in_l3_red,
  output logic            out_valid,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_green,
  output logic [7:0]      out_red,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_wdata
);

  localparam int NUM_STAGES = (MAX_LAYERS < lbc_pkg::INPUT_LAYERS) ?
                              MAX_LAYERS : lbc_pkg::INPUT_LAYERS;

  lbc_pkg::cfg_t  cfg;
  lbc_pkg::pix_t  in_px  [lbc_pkg::INPUT_LAYERS];
  lbc_pkg::pix_t  canvas [NUM_STAGES+1];
  logic [NUM_STAGES:0] vld;
  logic           out_valid_r;
  lbc_pkg::px_t   out_blue_r;
  lbc_pkg::px_t   out_green_r;
  lbc_pkg::px_t   out_red_r;

  // The pipeline takes a word every cycle.
  assign busy = 1'b0;

  lbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Gather the input word into per-layer pixels.
  assign in_px[0][lbc_pkg::CH_BLUE]  = in_l1_blue;
  assign in_px[0][lbc_pkg::CH_GREEN] = in_l1_green;
  assign in_px[0][lbc_pkg::CH_RED]   = in_l1_red;
  assign in_px[1][lbc_pkg::CH_BLUE]  = in_l2_blue;
  assign in_px[1][lbc_pkg::CH_GREEN] = in_l2_green;
  assign in_px[1][lbc_pkg::CH_RED]   = in_l2_red;
  assign in_px[2][lbc_pkg::CH_BLUE]  = in_l3_blue;
  assign in_px[2][lbc_pkg::CH_GREEN] = in_l3_green;
  assign in_px[2][lbc_pkg::CH_RED]   = in_l3_red;

  // The canvas starts black.
  assign canvas[0] = '0;
  assign vld[0]    = start && !busy;

  // Layer chain; later layers see their pixel delayed to meet the canvas.
  for (genvar l = 0; l < NUM_STAGES; l++) begin : g_layer
    lbc_pkg::pix_t px_l;

    if (l == 0) begin : g_direct
      assign px_l = in_px[0];
    end else begin : g_delay
      localparam int DEPTH = lbc_pkg::LANE_STAGES * l;
      lbc_pkg::pix_t sh_r [DEPTH];

      always_ff @(posedge clk) begin
        sh_r[0] <= in_px[l];
        for (int i = 1; i < DEPTH; i++) begin
          sh_r[i] <= sh_r[i-1];
        end
      end

      assign px_l = sh_r[DEPTH-1];
    end

    lbc_layer u_layer (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_i  (vld[l]),
      .canvas_i (canvas[l]),
      .px_i     (px_l),
      .mode_i   (cfg.mode[l]),
      .keep_i   (cfg.keep[l]),
      .active_i (int'(cfg.layer_count) > l),
      .valid_o  (vld[l+1]),
      .canvas_o (canvas[l+1])
    );
  end

  // Output stage merges the three channel lanes into one result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_blue_r  <= canvas[NUM_STAGES][lbc_pkg::CH_BLUE];
    out_green_r <= canvas[NUM_STAGES][lbc_pkg::CH_GREEN];
    out_red_r   <= canvas[NUM_STAGES][lbc_pkg::CH_RED];
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_blue_r;
  assign out_green = out_green_r;
  assign out_red   = out_red_r;

  // A result word only follows a word leaving the last layer.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld[NUM_STAGES]))
    else $error("layer_blend_compositor_unit: result without a source word");

  // Every word leaving the last layer becomes a result word.
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NUM_STAGES] |=> out_valid)
    else $error("layer_blend_compositor_unit: result word dropped");

endmodule

`default_nettype wire

/* test/layer_blend_compositor_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for layer_blend_compositor_unit: directed and random pixels under
// changing layer settings, each result checked against a scoreboard that composites
// the same pixel. Depends on lbc_pkg and the RTL under hdl/.

module layer_blend_compositor_unit_test;

  localparam int LAYER_LIMIT  = 3;
  localparam int PIPE_LATENCY = 4 * LAYER_LIMIT + 1;
  localparam int NUM_REGS     = int'(lbc_pkg::REG_KEEP_L3) + 1;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PIXELS = 650;
  localparam int SETTING_RUNS  = 28;
  localparam int CYCLE_LIMIT   = 100000;

  typedef lbc_pkg::pix_t [lbc_pkg::INPUT_LAYERS-1:0] layers_t;

  // Scoreboard: shadow copy of the settings and the queue of expected pixels.
  class pixel_scoreboard;
    logic [1:0]    layer_count;
    logic [2:0]    mode [lbc_pkg::INPUT_LAYERS];
    logic [6:0]    keep [lbc_pkg::INPUT_LAYERS];
    lbc_pkg::pix_t expected_pixels [$];
    int            errors;

    function new();
      layer_count = 2'd3;
      for (int l = 0; l < lbc_pkg::INPUT_LAYERS; l++) begin
        mode[l] = lbc_pkg::MODE_ADD;
        keep[l] = 7'd0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [6:0] data);
      case (idx)
        lbc_pkg::REG_LAYER_COUNT: layer_count = data[1:0];
        lbc_pkg::REG_MODE_L1, lbc_pkg::REG_MODE_L2, lbc_pkg::REG_MODE_L3:
          mode[idx - lbc_pkg::REG_MODE_L1] = data[2:0];
        lbc_pkg::REG_KEEP_L1, lbc_pkg::REG_KEEP_L2, lbc_pkg::REG_KEEP_L3:
          keep[idx - lbc_pkg::REG_KEEP_L1] = data;
        default: ;
      endcase
    endfunction

    // One channel of the canvas blended with one channel of a layer.
    function int unsigned blend_value(logic [2:0] blend, int unsigned canvas,
                                      int unsigned layer);
      case (blend)
        lbc_pkg::MODE_ADD:  return (canvas + layer > 255) ? 255 : canvas + layer;
        lbc_pkg::MODE_SUB:  return (canvas > layer) ? canvas - layer : 0;
        lbc_pkg::MODE_MUL:  return (canvas * layer) / 255;
        lbc_pkg::MODE_LITE: return (canvas > layer) ? canvas : layer;
        lbc_pkg::MODE_DIFF: return (canvas > layer) ? canvas - layer : layer - canvas;
        default:            return canvas;
      endcase
    endfunction

    // Composite an accepted word over black and queue the pixel it must produce.
    function void composite_expected(layers_t px);
      int unsigned   canvas [lbc_pkg::CHANNELS];
      int unsigned   count;
      int unsigned   pct;
      int unsigned   prev;
      lbc_pkg::pix_t result;
      for (int c = 0; c < lbc_pkg::CHANNELS; c++) canvas[c] = 0;
      count = layer_count;
      if (count > LAYER_LIMIT) count = LAYER_LIMIT;
      for (int l = 0; l < count; l++) begin
        pct = (keep[l] > lbc_pkg::PCT_FULL) ? lbc_pkg::PCT_FULL : keep[l];
        for (int c = 0; c < lbc_pkg::CHANNELS; c++) begin
          prev = canvas[c];
          canvas[c] = (blend_value(mode[l], prev, px[l][c]) * (100 - pct) + pct * prev) / 100;
        end
      end
      for (int c = 0; c < lbc_pkg::CHANNELS; c++) result[c] = canvas[c][7:0];
      expected_pixels = {expected_pixels, result};
    endfunction

    function void compare_channel(string name, lbc_pkg::px_t expected,
                                  lbc_pkg::px_t actual);
      if (expected !== actual) begin
        $error("%s: expected %0d, actual %0d", name, expected, actual);
        errors++;
      end
    endfunction

    function void check_pixel(lbc_pkg::px_t blue, lbc_pkg::px_t green, lbc_pkg::px_t red);
      lbc_pkg::pix_t expected;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: blue %0d green %0d red %0d", blue, green, red);
        errors++;
        return;
      end
      expected = expected_pixels.pop_front();
      compare_channel("out_blue", expected[lbc_pkg::CH_BLUE], blue);
      compare_channel("out_green", expected[lbc_pkg::CH_GREEN], green);
      compare_channel("out_red", expected[lbc_pkg::CH_RED], red);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_l1_blue = '0, in_l1_green = '0, in_l1_red = '0;
  logic [7:0] in_l2_blue = '0, in_l2_green = '0, in_l2_red = '0;
  logic [7:0] in_l3_blue = '0, in_l3_green = '0, in_l3_red = '0;
  logic       out_valid;
  logic [7:0] out_blue, out_green, out_red;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  pixel_scoreboard sb = new();
  logic [6:0]      settings [NUM_REGS];
  int              idle_pct = 0;
  int              cycle_count = 0;

  layer_blend_compositor_unit #(.MAX_LAYERS(LAYER_LIMIT)) DUT (
    .clk, .rst_n, .start, .busy,
    .in_l1_blue, .in_l1_green, .in_l1_red,
    .in_l2_blue, .in_l2_green, .in_l2_red,
    .in_l3_blue, .in_l3_green, .in_l3_red,
    .out_valid, .out_blue, .out_green, .out_red,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every result is on the ports for one cycle only and is checked at the edge ending it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_pixel(out_blue, out_green, out_red);
  end

  // Present one word, hold it until it is taken, then maybe leave a gap.
  task automatic send_pixel(input layers_t px);
    in_l1_blue <= px[0][lbc_pkg::CH_BLUE];
    in_l1_green <= px[0][lbc_pkg::CH_GREEN];
    in_l1_red <= px[0][lbc_pkg::CH_RED];
    in_l2_blue <= px[1][lbc_pkg::CH_BLUE];
    in_l2_green <= px[1][lbc_pkg::CH_GREEN];
    in_l2_red <= px[1][lbc_pkg::CH_RED];
    in_l3_blue <= px[2][lbc_pkg::CH_BLUE];
    in_l3_green <= px[2][lbc_pkg::CH_GREEN];
    in_l3_red <= px[2][lbc_pkg::CH_RED];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.composite_expected(px);
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait for every outstanding pixel before the settings change.
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all registers back to back, optionally followed by a write to an unused index.
  task automatic write_settings(input bit poke_unused);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_wdata <= settings[i];
      @(posedge clk);
      sb.write_reg(i[2:0], settings[i]);
    end
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= 7'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic layers_t fixed_pattern(int k);
    case (k % 4)
      0:       return '0;
      1:       return '1;
      2:       return {(lbc_pkg::INPUT_LAYERS * lbc_pkg::CHANNELS){8'hAA}};
      default: return {(lbc_pkg::INPUT_LAYERS * lbc_pkg::CHANNELS){8'h55}};
    endcase
  endfunction

  // Channels lean toward the extremes so saturation and flooring get exercised.
  function automatic layers_t random_pattern();
    layers_t p;
    for (int l = 0; l < lbc_pkg::INPUT_LAYERS; l++)
      for (int c = 0; c < lbc_pkg::CHANNELS; c++)
        case ($urandom_range(0, 7))
          0:       p[l][c] = 8'd0;
          1:       p[l][c] = 8'd255;
          default: p[l][c] = 8'($urandom_range(0, 255));
        endcase
    return p;
  endfunction

  function automatic logic [6:0] random_keep();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return lbc_pkg::PCT_FULL;
      2:       return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  // Modes are mostly defined ones; upper data bits are junk the block must drop.
  function automatic logic [6:0] random_mode();
    logic [2:0] m;
    m = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    return {4'($urandom), m};
  endfunction

  function automatic logic [6:0] random_count();
    logic [6:0] w;
    w = 7'($urandom);
    if ($urandom_range(0, 1) == 1) w[1:0] = 2'd3;
    return w;
  endfunction

  task automatic directed_run(input int n);
    for (int k = 0; k < n; k++) send_pixel(fixed_pattern(k));
    drain_results();
  endtask

  initial begin
    int idle_table [4];
    idle_table = '{0, 61, 0, 19};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings out of reset: three layers added with nothing kept.
    directed_run(4);
    // Add, multiply and difference with keep at none, all and half.
    settings = '{7'd3, 7'(lbc_pkg::MODE_ADD), 7'(lbc_pkg::MODE_MUL),
                 7'(lbc_pkg::MODE_DIFF), 7'd0, 7'd100, 7'd50};
    write_settings(1'b0);
    directed_run(4);
    // Lighten, subtract and multiply with nearly full and nearly empty keep.
    settings = '{7'd3, 7'(lbc_pkg::MODE_LITE), 7'(lbc_pkg::MODE_SUB),
                 7'(lbc_pkg::MODE_MUL), 7'd99, 7'd1, 7'd0};
    write_settings(1'b0);
    directed_run(3);
    // Count of two from junk-laden data, an undefined mode, keep above 100, unused index.
    settings = '{7'h7E, 7'(lbc_pkg::MODE_DIFF), 7'd5, 7'(lbc_pkg::MODE_LITE),
                 7'd127, 7'd0, 7'd100};
    write_settings(1'b1);
    directed_run(3);
    // Zero layers: the result stays black.
    settings = '{7'h7C, 7'(lbc_pkg::MODE_ADD), 7'(lbc_pkg::MODE_ADD),
                 7'(lbc_pkg::MODE_ADD), 7'd0, 7'd0, 7'd0};
    write_settings(1'b0);
    directed_run(2);
    // Single layer with undefined modes behind it.
    settings = '{7'd1, 7'(lbc_pkg::MODE_LITE), 7'd6, 7'd7, 7'd0, 7'd0, 7'd0};
    write_settings(1'b0);
    directed_run(2);
    // An undefined mode passing a lit canvas through to a subtract.
    settings = '{7'd3, 7'(lbc_pkg::MODE_LITE), 7'd7, 7'(lbc_pkg::MODE_SUB),
                 7'd0, 7'd0, 7'd33};
    write_settings(1'b0);
    directed_run(3);

    // Random words under random settings, through each idling phase.
    for (int run = 0; run < SETTING_RUNS; run++) begin
      settings[lbc_pkg::REG_LAYER_COUNT] = random_count();
      for (int l = 0; l < lbc_pkg::INPUT_LAYERS; l++) begin
        settings[int'(lbc_pkg::REG_MODE_L1) + l] = random_mode();
        settings[int'(lbc_pkg::REG_KEEP_L1) + l] = random_keep();
      end
      write_settings($urandom_range(0, 1));
      idle_pct = idle_table[run * 4 / SETTING_RUNS];
      for (int k = 0; k < RANDOM_PIXELS / SETTING_RUNS; k++) send_pixel(random_pattern());
      drain_results();
    end

    repeat (PIPE_LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lbc_pkg.sv
hdl/lbc_cfg_regs.sv
hdl/lbc_lane.sv
hdl/lbc_layer.sv
hdl/layer_blend_compositor_unit.sv
test/layer_blend_compositor_unit_test.sv
